@@ hw/rtl/radix_digit_emitter_defines.svh @@
// Assertion macros shared by the radix digit emitter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef RADIX_DIGIT_EMITTER_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_DEFINES_SVH

// Same-cycle implication, checking disabled while in reset.
`define RDE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("radix_digit_emitter: same-cycle check failed");

// Next-cycle implication, checking disabled while in reset.
`define RDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("radix_digit_emitter: next-cycle check failed");

`endif

@@ hw/rtl/rde_pkg.sv @@
// Shared types, constants and the digit character map of the radix digit emitter.
// No dependencies.
package rde_pkg;

	localparam int VALUE_PORT_W = 64;
	localparam int RADIX_W      = 5;
	localparam int DIGIT_W      = 4;
	localparam int CHAR_W       = 7;
	localparam int POS_W        = 6;
	localparam int COUNT_W      = 7;
	localparam int STACK_DEPTH  = 64;
	localparam int STACK_AW     = 6;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 5;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPERCASE = 2'd1;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

	localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] DECIMAL_SPAN  = 7'd10;

	typedef struct packed {
		logic [VALUE_PORT_W-1:0] value;
	} value_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic [POS_W-1:0]  position;
		logic              is_last;
	} digit_item_t;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic               upper;
	} job_ctl_t;

	typedef struct packed {
		logic                 we;
		logic [STACK_AW-1:0]  waddr;
		logic [DIGIT_W-1:0]   wdigit;
		logic                 done;
		logic [COUNT_W-1:0]   count;
		logic                 upper;
	} gen_emit_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
	                                                     input logic upper);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (dx < DECIMAL_SPAN)
			return ASCII_ZERO + dx;
		else if (upper)
			return ASCII_UPPER_A + dx - DECIMAL_SPAN;
		else
			return ASCII_LOWER_A + dx - DECIMAL_SPAN;
	endfunction

endpackage

@@ hw/rtl/rde_stream_if.sv @@
// Valid/ready stream interface used for the value and digit channels.
// Payload type is set per instance; no other dependencies.
interface rde_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/rde_front.sv @@
// Front end: configuration registers, value intake, radix clamp and top-byte search.
// Depends on rde_pkg and rde_stream_if.
module rde_front #(
	parameter int VALUE_WIDTH = 64,
	parameter int NBYTES      = 8,
	parameter int TOPW        = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rde_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [rde_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rde_stream_if.sink                    values,
	output logic                          job_valid,
	input  logic                          job_ready,
	output logic [NBYTES*8-1:0]           job_value,
	output logic [TOPW-1:0]               job_top,
	output rde_pkg::job_ctl_t             job_ctl
);
	import rde_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	logic               uppercase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			uppercase_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_RADIX:     radix_q     <= cfg_wdata[RADIX_W-1:0];
				REG_UPPERCASE: uppercase_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign job_valid    = values.valid;
	assign values.ready = job_ready;
	assign job_value    = (NBYTES*8)'(values.payload.value[VALUE_WIDTH-1:0]);

	always_comb begin
		job_top = '0;
		for (int i = 0; i < NBYTES; i++) begin
			if (job_value[i*8 +: 8] != 8'd0)
				job_top = TOPW'(i);
		end
	end

	always_comb begin
		job_ctl.upper = uppercase_q;
		if (radix_q < RADIX_MIN)
			job_ctl.radix = RADIX_MIN;
		else if (radix_q > RADIX_MAX)
			job_ctl.radix = RADIX_MAX;
		else
			job_ctl.radix = radix_q;
	end

endmodule

@@ hw/rtl/rde_queue.sv @@
// Two-entry job queue between the front end and the digit generator.
// No dependencies.
module rde_queue #(
	parameter int WIDTH = 80
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

@@ hw/rtl/rde_digit_gen.sv @@
// Digit generator: repeated division by the radix, one quotient byte per cycle,
// remainders pushed onto the digit stack. Depends on rde_pkg.
module rde_digit_gen #(
	parameter int NBYTES = 8,
	parameter int TOPW   = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  logic [NBYTES*8-1:0] job_value,
	input  logic [TOPW-1:0]     job_top,
	input  rde_pkg::job_ctl_t   job_ctl,
	input  logic                emit_idle,
	output rde_pkg::gen_emit_t  gen_emit
);
	import rde_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	state_t              state_q;
	logic [NBYTES*8-1:0] quot_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [TOPW-1:0]     idx_q;
	logic [TOPW-1:0]     newtop_q;
	logic                seen_q;
	logic [COUNT_W-1:0]  n_q;
	logic [RADIX_W-1:0]  radix_q;
	logic                upper_q;
	logic                done_q;
	logic [COUNT_W-1:0]  count_q;

	logic [7:0]          cur_byte;
	logic [7:0]          qbyte;
	logic [DIGIT_W-1:0]  rem_next;
	logic                finish;
	logic                quot_zero;
	logic [TOPW-1:0]     top_next;

	// Restoring division of one byte by the radix, remainder carried in.
	always_comb begin
		logic [RADIX_W-1:0] t;
		logic [DIGIT_W-1:0] r;
		cur_byte = quot_q[idx_q*8 +: 8];
		r        = rem_q;
		qbyte    = '0;
		for (int j = 7; j >= 0; j--) begin
			t = {r, cur_byte[j]};
			if (t >= radix_q) begin
				t        = t - radix_q;
				qbyte[j] = 1'b1;
			end
			r = t[DIGIT_W-1:0];
		end
		rem_next = r;
	end

	assign finish    = (state_q == ST_DIV) && (idx_q == '0);
	assign quot_zero = !(seen_q || (qbyte != 8'd0));
	assign top_next  = (!seen_q && (qbyte != 8'd0)) ? idx_q : newtop_q;
	assign job_ready = (state_q == ST_IDLE) && emit_idle && !done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			quot_q   <= '0;
			rem_q    <= '0;
			idx_q    <= '0;
			newtop_q <= '0;
			seen_q   <= 1'b0;
			n_q      <= '0;
			radix_q  <= RADIX_RESET;
			upper_q  <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid && job_ready) begin
						quot_q   <= job_value;
						idx_q    <= job_top;
						rem_q    <= '0;
						newtop_q <= '0;
						seen_q   <= 1'b0;
						n_q      <= '0;
						radix_q  <= job_ctl.radix;
						upper_q  <= job_ctl.upper;
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					quot_q[idx_q*8 +: 8] <= qbyte;
					if (finish) begin
						n_q      <= n_q + 1'b1;
						rem_q    <= '0;
						seen_q   <= 1'b0;
						newtop_q <= '0;
						idx_q    <= top_next;
						if (quot_zero || n_q == COUNT_W'(STACK_DEPTH - 1)) begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
							count_q <= n_q + 1'b1;
						end
					end else begin
						rem_q <= rem_next;
						idx_q <= idx_q - 1'b1;
						if (!seen_q && qbyte != 8'd0) begin
							seen_q   <= 1'b1;
							newtop_q <= idx_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		gen_emit.we     = finish;
		gen_emit.waddr  = n_q[STACK_AW-1:0];
		gen_emit.wdigit = rem_next;
		gen_emit.done   = done_q;
		gen_emit.count  = count_q;
		gen_emit.upper  = upper_q;
	end

endmodule

@@ hw/rtl/rde_emitter.sv @@
// Back end: digit stack memory and emission of characters from the top of the stack.
// Depends on rde_pkg, rde_stream_if and radix_digit_emitter_defines.svh.
module rde_emitter (
	input  logic               clk,
	input  logic               arst_n,
	input  rde_pkg::gen_emit_t gen_emit,
	output logic               emit_idle,
	rde_stream_if.source       digits
);
	import rde_pkg::*;
	`include "radix_digit_emitter_defines.svh"

	logic [DIGIT_W-1:0]  stack [STACK_DEPTH];
	logic                active_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [COUNT_W-1:0]  k_q;
	logic                upper_q;
	logic                rd_s1;
	logic [POS_W-1:0]    pos_s1;
	logic                last_s1;
	logic [DIGIT_W-1:0]  rdata_s1;
	logic                out_valid_q;
	digit_item_t         out_q;

	logic                issue;
	logic                issue_last;
	logic [STACK_AW-1:0] raddr;

	assign issue      = active_q && !rd_s1 && (!out_valid_q || digits.ready);
	assign issue_last = (k_q + 1'b1 == cnt_q);
	assign raddr      = STACK_AW'(cnt_q - 1'b1 - k_q);
	assign emit_idle  = !active_q && !rd_s1;

	always_ff @(posedge clk) begin
		if (gen_emit.we)
			stack[gen_emit.waddr] <= gen_emit.wdigit;
		if (issue)
			rdata_s1 <= stack[raddr];
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pos_s1  <= k_q[POS_W-1:0];
			last_s1 <= issue_last;
		end
		if (rd_s1)
			out_q <= '{digit_char: digit_to_ascii(rdata_s1, upper_q),
			           position:   pos_s1,
			           is_last:    last_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cnt_q       <= '0;
			k_q         <= '0;
			upper_q     <= 1'b0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= issue;
			if (gen_emit.done) begin
				active_q <= 1'b1;
				cnt_q    <= gen_emit.count;
				k_q      <= '0;
				upper_q  <= gen_emit.upper;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
				if (issue_last)
					active_q <= 1'b0;
			end
			if (rd_s1)
				out_valid_q <= 1'b1;
			else if (digits.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign digits.valid   = out_valid_q;
	assign digits.payload = out_q;

	`RDE_ASSERT_IMPL(a_land_slot_free, clk, arst_n, rd_s1, !out_valid_q)
	`RDE_ASSERT_IMPL(a_no_write_live, clk, arst_n, gen_emit.we, !active_q && !rd_s1)
	`RDE_ASSERT_IMPL(a_done_when_idle, clk, arst_n, gen_emit.done,
		!active_q && !rd_s1 && gen_emit.count != '0)
	`RDE_ASSERT_NEXT(a_last_read_ends, clk, arst_n, issue && issue_last, !active_q && rd_s1)

endmodule

@@ hw/rtl/radix_digit_emitter.sv @@
// Radix digit emitter: a value becomes its digits in radix 2..16, most significant first.
// The queue registers each value for the generator, which divides byte-serially from the top
// non-zero byte down for each digit; the emitter reads each digit into a read stage, then into
// the output register, and issues no new read while one is in the read stage.
// Throughput: one value per run of division plus emission; the byte-serial divider sets it,
// and values wait for an idle emitter. A two-entry queue holds further values meanwhile.
// Reset (arst_n, asynchronous): control cleared, radix 10, lowercase; digit stack not cleared.
module radix_digit_emitter #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rde_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rde_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rde_stream_if.sink                     values,
	rde_stream_if.source                   digits
);
	import rde_pkg::*;

	localparam int NBYTES = (VALUE_WIDTH + 7) / 8;
	localparam int QW     = NBYTES * 8;
	localparam int TOPW   = (NBYTES > 1) ? $clog2(NBYTES) : 1;
	localparam int CTLW   = $bits(job_ctl_t);
	localparam int QDW    = QW + TOPW + CTLW;

	logic            f_valid;
	logic            f_ready;
	logic [QW-1:0]   f_value;
	logic [TOPW-1:0] f_top;
	job_ctl_t        f_ctl;

	logic            q_valid;
	logic            q_ready;
	logic [QDW-1:0]  q_data;

	logic            emit_idle;
	gen_emit_t       gen_emit;

	rde_front #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NBYTES      (NBYTES),
		.TOPW        (TOPW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.values    (values),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job_value (f_value),
		.job_top   (f_top),
		.job_ctl   (f_ctl)
	);

	rde_queue #(
		.WIDTH (QDW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_value, f_top, f_ctl}),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	rde_digit_gen #(
		.NBYTES (NBYTES),
		.TOPW   (TOPW)
	) u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job_value (q_data[QDW-1 -: QW]),
		.job_top   (q_data[CTLW +: TOPW]),
		.job_ctl   (q_data[CTLW-1:0]),
		.emit_idle (emit_idle),
		.gen_emit  (gen_emit)
	);

	rde_emitter u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.gen_emit  (gen_emit),
		.emit_idle (emit_idle),
		.digits    (digits)
	);

endmodule

@@ verif/radix_digit_emitter_tb.sv @@
// Self-checking testbench for radix_digit_emitter: values in, ASCII digit transfers out.
// Predicts every digit at value acceptance and checks each transfer in order.
// Depends on rde_pkg, rde_stream_if and the radix_digit_emitter RTL.
module radix_digit_emitter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rde_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int DRAIN_CAP   = 50000;
	localparam int SETTLE_CYC  = 16;
	localparam int HOLD_CYC    = 400;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_pattern_e;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rde_stream_if #(.payload_t(value_item_t)) values_ch ();
	rde_stream_if #(.payload_t(digit_item_t)) digits_ch ();

	radix_digit_emitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.values    (values_ch),
		.digits    (digits_ch)
	);

	bit [RADIX_W-1:0] radix_reg;
	bit               upper_reg;
	digit_item_t      pending_digits[$];
	int unsigned      fail_count;
	int unsigned      burst_left;
	bit               hold_request;
	int unsigned      hold_left;
	rx_pattern_e      rx_pattern;
	int unsigned      pattern_left;
	int unsigned      rx_tick;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic void predict_digits(input bit [63:0] v);
		bit [63:0]        q;
		bit [DIGIT_W-1:0] stack [STACK_DEPTH];
		bit [RADIX_W-1:0] r;
		bit [CHAR_W-1:0]  d;
		int               n;
		digit_item_t      item;
		r = radix_reg;
		if (r < RADIX_MIN)
			r = RADIX_MIN;
		else if (r > RADIX_MAX)
			r = RADIX_MAX;
		q = v;
		n = 0;
		do begin
			stack[n] = DIGIT_W'(q % r);
			q = q / r;
			n++;
		end while (q != 0 && n < STACK_DEPTH);
		for (int k = 0; k < n; k++) begin
			d = CHAR_W'(stack[n - 1 - k]);
			if (d < DECIMAL_SPAN)
				item.digit_char = ASCII_ZERO + d;
			else
				item.digit_char = (upper_reg ? ASCII_UPPER_A : ASCII_LOWER_A) + d - DECIMAL_SPAN;
			item.position = POS_W'(k);
			item.is_last  = (k == n - 1);
			pending_digits.push_back(item);
		end
	endfunction

	// digit sink: checks each transfer, then drives ready for the next cycle
	always @(posedge clk) begin
		if (digits_ch.valid && digits_ch.ready) begin
			if (pending_digits.size() == 0) begin
				$display("%0t: unexpected digit transfer, actual %p", $time, digits_ch.payload);
				fail_count++;
			end else begin
				digit_item_t exp_d;
				exp_d = pending_digits.pop_front();
				if (digits_ch.payload.digit_char !== exp_d.digit_char) begin
					$display("%0t: digit_char expected %h actual %h", $time,
						exp_d.digit_char, digits_ch.payload.digit_char);
					fail_count++;
				end
				if (digits_ch.payload.position !== exp_d.position) begin
					$display("%0t: position expected %0d actual %0d", $time,
						exp_d.position, digits_ch.payload.position);
					fail_count++;
				end
				if (digits_ch.payload.is_last !== exp_d.is_last) begin
					$display("%0t: is_last expected %b actual %b", $time,
						exp_d.is_last, digits_ch.payload.is_last);
					fail_count++;
				end
			end
		end
		if (hold_request) begin
			hold_left = HOLD_CYC;
			hold_request = 1'b0;
		end
		if (pattern_left == 0) begin
			rx_pattern = rx_pattern_e'($urandom_range(RX_OPEN, RX_SPARSE));
			pattern_left = $urandom_range(20, 200);
		end else
			pattern_left--;
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			digits_ch.ready <= 1'b0;
		end else begin
			case (rx_pattern)
				RX_OPEN:   digits_ch.ready <= 1'b1;
				RX_RANDOM: digits_ch.ready <= 1'($urandom_range(0, 1));
				default:   digits_ch.ready <= (rx_tick % 4 == 0);
			endcase
		end
	end

	task automatic send_value(input bit [63:0] v);
		if (burst_left == 0) begin
			values_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		values_ch.valid <= 1'b1;
		values_ch.payload <= '{value: v};
		do
			@(posedge clk);
		while (!values_ch.ready);
		predict_digits(v);
	endtask

	task automatic wait_idle();
		int unsigned waited;
		values_ch.valid <= 1'b0;
		waited = 0;
		while (pending_digits.size() != 0 && waited < DRAIN_CAP) begin
			@(posedge clk);
			waited++;
		end
		if (pending_digits.size() != 0) begin
			$display("%0t: %0d expected digits never arrived", $time, pending_digits.size());
			fail_count++;
			pending_digits.delete();
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RADIX)
			radix_reg = data;
		else if (idx == REG_UPPERCASE)
			upper_reg = data[0];
		@(posedge clk);
	endtask

	function automatic bit [63:0] random_value();
		bit [63:0] v;
		case ($urandom_range(0, 9))
			0:       v = '0;
			1:       v = '1;
			2:       v = 64'd1 << $urandom_range(0, 63);
			default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
		return v;
	endfunction

	task automatic test_reset_defaults();
		send_value(64'd0);
		send_value(64'd1);
		send_value(64'd9);
		send_value(64'd10);
		send_value(64'd12345);
		send_value('1);
		wait_idle();
	endtask

	task automatic test_radix_extremes();
		write_reg(REG_RADIX, 5'd2);
		send_value(64'd0);
		send_value('1);
		send_value(64'h8000_0000_0000_0000);
		wait_idle();
		write_reg(REG_RADIX, 5'd16);
		send_value(64'hfedc_ba98_7654_3210);
		send_value('1);
		wait_idle();
		write_reg(REG_UPPERCASE, 5'd1);
		send_value(64'hfedc_ba98_7654_3210);
		wait_idle();
		// only bit 0 of the case register counts
		write_reg(REG_UPPERCASE, 5'b11110);
		send_value(64'h0000_0000_00ab_cdef);
		wait_idle();
		write_reg(REG_RADIX, 5'd0);
		send_value(64'd5);
		wait_idle();
		write_reg(REG_RADIX, 5'd1);
		send_value(64'd6);
		wait_idle();
		write_reg(REG_RADIX, 5'd17);
		send_value(64'habc);
		wait_idle();
		write_reg(REG_RADIX, 5'd31);
		send_value(64'h5a5a_a5a5_0f0f_f0f0);
		wait_idle();
		write_reg(REG_RADIX, 5'd3);
		write_reg(REG_UPPERCASE, 5'd1);
		// writes to unused indexes must leave both registers alone
		write_reg(REG_SPARE_2, 5'd16);
		write_reg(REG_SPARE_3, 5'h1f);
		send_value(64'd80);
		send_value(64'd1 << 40);
		wait_idle();
	endtask

	task automatic test_backpressure();
		write_reg(REG_RADIX, 5'd10);
		write_reg(REG_UPPERCASE, 5'd0);
		hold_request = 1'b1;
		burst_left = 30;
		for (int i = 0; i < 8; i++)
			send_value(random_value());
		wait_idle();
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0:       write_reg(REG_RADIX, 5'd2);
				1:       write_reg(REG_RADIX, 5'd16);
				default: write_reg(REG_RADIX, 5'($urandom_range(0, 31)));
			endcase
			write_reg(REG_UPPERCASE, 5'($urandom_range(0, 31)));
			for (int i = 0; i < 25; i++)
				send_value(random_value());
			wait_idle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		values_ch.valid <= 1'b0;
		values_ch.payload <= '0;
		radix_reg = RADIX_RESET;
		upper_reg = 1'b0;
		fail_count = 0;
		burst_left = 0;
		hold_request = 1'b0;
		hold_left = 0;
		rx_pattern = RX_OPEN;
		pattern_left = 0;
		rx_tick = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_radix_extremes();
		test_backpressure();
		test_random_settings();
		if (fail_count == 0)
			$display("radix_digit_emitter_tb passed");
		else
			$display("radix_digit_emitter_tb failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("radix_digit_emitter_tb failed");
		$finish;
	end

endmodule

@@ radix_digit_emitter.f @@
+incdir+hw/rtl
hw/rtl/rde_pkg.sv
hw/rtl/rde_stream_if.sv
hw/rtl/rde_front.sv
hw/rtl/rde_queue.sv
hw/rtl/rde_digit_gen.sv
hw/rtl/rde_emitter.sv
hw/rtl/radix_digit_emitter.sv
verif/radix_digit_emitter_tb.sv
